// ----- sv/pidff_pkg.sv -----
package pidff_pkg;

  // filter order and output clamp
  localparam int FF_ORDER  = 3;
  localparam int OUT_LIMIT = 13107;

  // datapath widths
  localparam int DEV_W   = 17;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 64;
  localparam int FF_W    = 48;
  localparam int FFACC_W = 52;
  localparam int DR_W    = 28;
  localparam int NUM_IW  = $clog2(FF_ORDER + 1);
  localparam int HIST_IW = $clog2(FF_ORDER);

  // payload types
  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [15:0] feedback;
  } in_t;

  typedef struct packed {
    logic signed [14:0] drive;
    logic               limited;
  } out_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_ENABLE  = 3'd5;

  // register reset values
  localparam logic [31:0] PROP_GAIN_RST  = 32'd655360;
  localparam logic [31:0] INTEG_GAIN_RST = 32'd19661;
  localparam logic [31:0] DERIV_GAIN_RST = 32'd0;
  localparam logic [15:0] INTEG_THR_RST  = 16'd200;
  localparam logic [9:0]  DERIV_RATE_RST = 10'd1;

  // cap on the integral term magnitude
  localparam logic [ACC_W-1:0] ITERM_CAP = 64'h2000_0000_0000_0000;

  // filter coefficients, q16.16: numerator b0..b3, denominator a1..a3
  localparam logic signed [MUL_W-1:0] FF_NUM [FF_ORDER+1] = '{
    33'sd16361973, -33'sd48876932, 33'sd48745520, -33'sd16230462};
  localparam logic signed [MUL_W-1:0] FF_DEN [FF_ORDER] = '{
    -33'sd64710, -33'sd65215, 33'sd65031};

  // sequencer steps, at most one multiplier issue per step
  localparam int S_DR    = 0;                       // deviation change times rate
  localparam int S_P     = 1;                       // proportional
  localparam int S_D     = 2;                       // derivative
  localparam int S_I     = 3;                       // integral
  localparam int S_B0    = 4;                       // numerator taps
  localparam int S_A0    = S_B0 + FF_ORDER + 1;     // denominator taps, two halves each
  localparam int S_FFEND = S_A0 + 2 * FF_ORDER;     // last filter product lands
  localparam int S_SAT   = S_FFEND + 1;             // filter saturate and history
  localparam int S_OUT   = S_SAT + 1;               // truncate, clamp, write result
  localparam int STEP_W  = $clog2(S_OUT + 1);

  typedef logic [STEP_W-1:0] step_t;

  // sequencer status toward the datapath
  typedef struct packed {
    logic  run;
    step_t step;
    logic  done;
  } seq_t;

endpackage

// ----- sv/pid_with_feedforward_iir.sv -----
// pid controller with integral separation and a fixed third-order iir
// feedforward on the setpoint.
// input channel: in_valid/in_ready/in_data carry one setpoint and feedback
// sample per beat. result channel: out_valid/out_ready/out_data carry the
// clamped drive and the limited flag, one result beat per input beat.
// configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write the gains,
// threshold, derivative rate and feedforward enable; cfg_ready is always
// high and writes are meant for when no sample is in flight.
// sequencing: one multiplier is shared by all terms, at most one product per step:
// 4 pid steps, FF_ORDER+1 numerator taps, 2*FF_ORDER denominator halves,
// one step for the last product to land, saturate and output: 17 steps.
// the result becomes valid in the same cycle that in_ready rises again.
// in_ready is low while a sample is in work.
// a finished result sits in the output register; the next sample may be
// taken meanwhile, and its final step waits while that register is full
// and out_ready is low.
// reset (rst_n low, synchronous) restores register defaults and clears the
// integral, the previous deviation and the filter history.
module pid_with_feedforward_iir (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  pidff_pkg::in_t                        in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pidff_pkg::out_t                       out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pidff_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                           cfg_data
);
  import pidff_pkg::*;

  // configuration registers
  logic [31:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [15:0] integ_thr_r;
  logic [9:0]  deriv_rate_r;
  logic        ff_en_r;

  // controller state
  logic signed [31:0]      integ_sum_r;
  logic signed [DEV_W-1:0] prev_dev_r;
  logic signed [15:0]      xh_r [FF_ORDER];
  logic signed [FF_W-1:0]  yh_r [FF_ORDER];

  // per-sample working registers
  logic signed [15:0]      sp_r;
  logic signed [DEV_W-1:0] dev_r;
  logic                    ien_r;
  logic [31:0]             im_r;
  logic signed [DR_W-1:0]  dr_r;
  logic signed [ACC_W-1:0] tot_r;
  logic signed [FFACC_W-1:0] ff_acc_r;

  // result register
  logic out_valid_r;
  out_t out_data_r;

  seq_t seq_s;
  logic out_hold;
  logic in_ready_s;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;

  assign cfg_ready = 1'b1;
  assign out_hold  = out_valid_r && !out_ready;
  assign in_ready  = in_ready_s;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pidff_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_hold (out_hold),
    .in_ready (in_ready_s),
    .seq      (seq_s)
  );

  pidff_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      integ_thr_r  <= INTEG_THR_RST;
      deriv_rate_r <= DERIV_RATE_RST;
      ff_en_r      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:  prop_gain_r  <= cfg_data;
        CFG_INTEG_GAIN: integ_gain_r <= cfg_data;
        CFG_DERIV_GAIN: deriv_gain_r <= cfg_data;
        CFG_INTEG_THR:  integ_thr_r  <= cfg_data[15:0];
        CFG_DERIV_RATE: deriv_rate_r <= cfg_data[9:0];
        CFG_FF_ENABLE:  ff_en_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // step decode
  logic              is_b_issue, is_a_issue, is_b_acc, is_a_acc;
  step_t             b_off, a_off, a_acc_off;
  logic [NUM_IW-1:0] bk;
  logic [HIST_IW-1:0] aj;
  logic signed [17:0] diff;
  logic signed [FF_W-1:0] ysel;

  assign is_b_issue = seq_s.step >= step_t'(S_B0) && seq_s.step <= step_t'(S_B0 + FF_ORDER);
  assign is_a_issue = seq_s.step >= step_t'(S_A0) && seq_s.step < step_t'(S_FFEND);
  assign is_b_acc   = seq_s.step > step_t'(S_B0) && seq_s.step <= step_t'(S_A0);
  assign is_a_acc   = seq_s.step > step_t'(S_A0) && seq_s.step <= step_t'(S_FFEND);
  assign b_off      = seq_s.step - step_t'(S_B0);
  assign a_off      = seq_s.step - step_t'(S_A0);
  assign a_acc_off  = seq_s.step - step_t'(S_A0 + 1);
  assign bk         = b_off[NUM_IW-1:0];
  assign aj         = HIST_IW'(a_off >> 1);
  assign diff       = 18'(dev_r) - 18'(prev_dev_r);
  assign ysel       = yh_r[aj];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (seq_s.step == step_t'(S_DR)) begin
      mul_a = MUL_W'(diff);
      mul_b = MUL_W'(deriv_rate_r);
    end else if (seq_s.step == step_t'(S_P)) begin
      mul_a = MUL_W'(prop_gain_r);
      mul_b = MUL_W'(dev_r);
    end else if (seq_s.step == step_t'(S_D)) begin
      mul_a = MUL_W'(deriv_gain_r);
      mul_b = MUL_W'(dr_r);
    end else if (seq_s.step == step_t'(S_I)) begin
      mul_a = MUL_W'(integ_gain_r);
      mul_b = MUL_W'(im_r);
    end else if (is_b_issue) begin
      mul_a = FF_NUM[bk];
      if (bk == '0) mul_b = MUL_W'(sp_r);
      else          mul_b = MUL_W'(xh_r[HIST_IW'(bk - NUM_IW'(1))]);
    end else if (is_a_issue) begin
      mul_a = FF_DEN[aj];
      if (!a_off[0]) mul_b = MUL_W'($signed(ysel[FF_W-1:FF_W/2]));
      else           mul_b = MUL_W'({1'b0, ysel[FF_W/2-1:0]});
    end
  end

  // integral update, deviation magnitude, integral term cap, filter output saturation
  logic signed [32:0]      isum;
  logic signed [31:0]      isat;
  logic [DEV_W-1:0]        dmag;
  logic [ACC_W-1:0]        ip, ipc;
  logic signed [FF_W-1:0]  ysat;

  always_comb begin
    isum = 33'(integ_sum_r) + 33'(dev_r);
    if (isum[32] != isum[31]) isat = isum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else                      isat = isum[31:0];
    dmag = dev_r[DEV_W-1] ? DEV_W'(-dev_r) : DEV_W'(dev_r);
    ip   = prod_r[ACC_W-1:0];
    ipc  = (ip > ITERM_CAP) ? ITERM_CAP : ip;
    if (ff_acc_r[FFACC_W-1:FF_W-1] == '0 || ff_acc_r[FFACC_W-1:FF_W-1] == '1)
      ysat = ff_acc_r[FF_W-1:0];
    else if (ff_acc_r[FFACC_W-1])
      ysat = {1'b1, {(FF_W-1){1'b0}}};
    else
      ysat = {1'b0, {(FF_W-1){1'b1}}};
  end

  // truncation toward zero and clamp
  logic [ACC_W-1:0]   tmag;
  logic [FF_W-1:0]    tq;
  logic               lim;
  logic [14:0]        umag;
  out_t               res;

  always_comb begin
    tmag = tot_r[ACC_W-1] ? ACC_W'(-tot_r) : ACC_W'(tot_r);
    tq   = tmag[ACC_W-1:16];
    lim  = tq > FF_W'(OUT_LIMIT);
    umag = lim ? 15'(OUT_LIMIT) : tq[14:0];
    res.drive   = tot_r[ACC_W-1] ? $signed(-umag) : $signed(umag);
    res.limited = lim;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready_s) begin
      sp_r  <= in_data.setpoint;
      dev_r <= DEV_W'(in_data.setpoint) - DEV_W'(in_data.feedback);
    end
  end

  // working registers, accumulate the product issued one step earlier
  always_ff @(posedge clk) begin
    if (seq_s.run) begin
      if (seq_s.step == step_t'(S_DR)) begin
        tot_r    <= '0;
        ff_acc_r <= '0;
        ien_r    <= dmag < DEV_W'(integ_thr_r);
      end
      if (seq_s.step == step_t'(S_P)) begin
        dr_r <= prod_r[DR_W-1:0];
        im_r <= integ_sum_r[31] ? 32'(-33'(integ_sum_r)) : 32'(integ_sum_r);
      end
      if (seq_s.step == step_t'(S_D) || seq_s.step == step_t'(S_I))
        tot_r <= tot_r + $signed(prod_r[ACC_W-1:0]);
      if (seq_s.step == step_t'(S_B0) && ien_r)
        tot_r <= integ_sum_r[31] ? tot_r - $signed(ipc) : tot_r + $signed(ipc);
      if (is_b_acc)
        ff_acc_r <= ff_acc_r + FFACC_W'(prod_r);
      if (is_a_acc) begin
        if (!a_acc_off[0]) ff_acc_r <= ff_acc_r - FFACC_W'(prod_r <<< 8);
        else               ff_acc_r <= ff_acc_r - FFACC_W'(prod_r >>> 16);
      end
      if (seq_s.step == step_t'(S_SAT) && ff_en_r)
        tot_r <= tot_r + ACC_W'(ysat);
    end
  end

  // controller state: integral, previous deviation, filter history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_sum_r <= '0;
      prev_dev_r  <= '0;
      for (int k = 0; k < FF_ORDER; k++) begin
        xh_r[k] <= '0;
        yh_r[k] <= '0;
      end
    end else if (seq_s.run) begin
      if (seq_s.step == step_t'(S_DR) && dmag < DEV_W'(integ_thr_r))
        integ_sum_r <= isat;
      if (seq_s.step == step_t'(S_SAT)) begin
        prev_dev_r <= dev_r;
        if (ff_en_r) begin
          for (int k = FF_ORDER - 1; k > 0; k--) begin
            xh_r[k] <= xh_r[k-1];
            yh_r[k] <= yh_r[k-1];
          end
          xh_r[0] <= sp_r;
          yh_r[0] <= ysat;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_s.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_s.done) out_data_r <= res;
  end

`ifndef SYNTH
  // a taken beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an input beat");

  // a result appears only from the final step
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(seq_s.done))
    else $error("result valid without a finished sample");

  // the integral moves only on the first step of a sample
  a_integ_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(integ_sum_r) |->
      ($past(seq_s.run) && $past(seq_s.step) == step_t'(S_DR)) || $past(!rst_n))
    else $error("integral changed outside its step");

  // a clamped result sits on the limit
  a_limit_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.limited |->
      out_data.drive == 15'(OUT_LIMIT) || out_data.drive == 15'(-OUT_LIMIT))
    else $error("limited flag set but drive is not at the limit");
`endif

endmodule

// ----- sv/pidff_mul.sv -----
module pidff_mul (
  input  logic                                 clk,
  input  logic signed [pidff_pkg::MUL_W-1:0]   mul_a,
  input  logic signed [pidff_pkg::MUL_W-1:0]   mul_b,
  output logic signed [pidff_pkg::PROD_W-1:0]  prod_r
);
  import pidff_pkg::*;

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

// ----- sv/pidff_seq.sv -----
module pidff_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_hold,
  output logic              in_ready,
  output pidff_pkg::seq_t   seq
);
  import pidff_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic  state_r, state_nxt;
  step_t step_r, step_nxt;
  logic  last_step;

  assign last_step = (step_r == step_t'(S_OUT));
  assign in_ready  = (state_r == ST_IDLE);

  // step counter, holds on the last step while the result register is full and out_ready is low
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          if (!out_hold) state_nxt = ST_IDLE;
        end else begin
          step_nxt = step_r + step_t'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign seq.run  = (state_r == ST_RUN);
  assign seq.step = step_r;
  assign seq.done = (state_r == ST_RUN) && last_step && !out_hold;

endmodule
